/* design/acoustic_godunov_step_unit_assert.svh */
// Assertion macros for the acoustic step unit.
// AGS_ASSERT checks a property at every rising clock edge outside reset.
// AGS_ASSERT_IMP checks that an antecedent implies a consequent in the same cycle.
`ifndef ACOUSTIC_GODUNOV_STEP_UNIT_ASSERT_SVH
`define ACOUSTIC_GODUNOV_STEP_UNIT_ASSERT_SVH
`ifndef SYNTH
`define AGS_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define AGS_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define AGS_ASSERT(name, clk, rstn, prop)
`define AGS_ASSERT_IMP(name, clk, rstn, ante, cons)
`endif
`endif

/* design/ags_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ags_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SRD,
    S_SLAT,
    S_E1,
    S_E2,
    S_E3,
    S_E4,
    S_U1,
    S_U2,
    S_EMIT
  } state_e;

  localparam int NUM_REGS = 8;

  localparam logic [2:0] REG_IMPEDANCE     = 3'd0;
  localparam logic [2:0] REG_INV_IMPEDANCE = 3'd1;
  localparam logic [2:0] REG_VELOCITY_GAIN = 3'd2;
  localparam logic [2:0] REG_PRESSURE_GAIN = 3'd3;
  localparam logic [2:0] REG_LEFT_U_GAIN   = 3'd4;
  localparam logic [2:0] REG_LEFT_P_GAIN   = 3'd5;
  localparam logic [2:0] REG_RIGHT_U_GAIN  = 3'd6;
  localparam logic [2:0] REG_RIGHT_P_GAIN  = 3'd7;

  localparam logic [31:0] REG_RESET [NUM_REGS] = '{
    32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_8000,
    32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000
  };

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         cell_index;
    logic signed [31:0] velocity_in;
    logic signed [31:0] pressure_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] velocity_out;
    logic signed [31:0] pressure_out;
    logic [31:0]        step_count;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] vel;
    logic signed [31:0] prs;
  } cell_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } satv_t;

endpackage

`default_nettype wire

/* design/ags_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ags_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/acoustic_godunov_step_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// One-dimensional linear acoustics engine holding velocity and pressure of CELLS cells
// in signed fixed point with FRAC_BITS fraction bits, stored in one synchronous RAM.
// After reset the RAM is cleared by a pass over all CELLS entries, during which no
// request is taken. A write request goes straight to the emit state; a read request
// makes one RAM read first. A step request sweeps the row once through the single RAM
// read port with a two-cell window: each cell goes through read, latch, edge multiply,
// edge average, update multiply and write back. One request is worked on at a time; a
// finished result waits in the output register while the next request is taken, and a
// result waits on a full output only in its emit state.
module acoustic_godunov_step_unit
  import ags_pkg::*;
#(
  parameter int CELLS     = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  `include "acoustic_godunov_step_unit_assert.svh"

  localparam int AW = $clog2(CELLS);
  localparam logic [AW:0] KLAST = (AW+1)'(CELLS - 1);
  localparam logic [AW:0] KEND  = (AW+1)'(CELLS);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // Saturating helpers on exact wide intermediates.
  function automatic logic signed [65:0] ext66(input logic signed [31:0] a);
    ext66 = {{34{a[31]}}, a};
  endfunction

  function automatic satv_t sat66(input logic signed [65:0] v);
    satv_t r;
    if (v > 66'sd2147483647) begin
      r.clip = 1'b1;
      r.val  = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r.clip = 1'b1;
      r.val  = 32'sh8000_0000;
    end else begin
      r.clip = 1'b0;
      r.val  = v[31:0];
    end
    sat66 = r;
  endfunction

  function automatic satv_t dif32(input logic signed [31:0] a, input logic signed [31:0] b);
    dif32 = sat66(ext66(a) - ext66(b));
  endfunction

  function automatic satv_t avg32(input logic signed [31:0] a, input logic signed [31:0] b,
                                  input logic signed [31:0] c);
    logic signed [65:0] t;
    t = ext66(a) + ext66(b) - ext66(c) + 66'sd1;
    avg32 = sat66(t >>> 1);
  endfunction

  function automatic satv_t mulsat(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + HALF) >>> FRAC_BITS;
    mulsat = sat66({{2{r[63]}}, r});
  endfunction

  // Configuration registers and the APB port.
  logic [31:0] cfg_q [NUM_REGS];
  logic        cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = cfg_q[paddr[4:2]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        cfg_q[r] <= REG_RESET[r];
      end
    end else if (cfg_we) begin
      cfg_q[paddr[4:2]] <= pwdata;
    end
  end

  logic signed [31:0] imp, inv_imp, vel_gain, prs_gain;
  assign imp      = cfg_q[REG_IMPEDANCE];
  assign inv_imp  = cfg_q[REG_INV_IMPEDANCE];
  assign vel_gain = cfg_q[REG_VELOCITY_GAIN];
  assign prs_gain = cfg_q[REG_PRESSURE_GAIN];

  // Sequencer state and the sweep window.
  state_e state_q, state_d;
  logic [AW:0] k_q, k_d;
  cell_t prev_q, prev_d, cur_q, cur_d;
  logic signed [31:0] eu_prev_q, eu_prev_d, ep_prev_q, ep_prev_d;
  logic signed [31:0] eu_cur_q, eu_cur_d, ep_cur_q, ep_cur_d;
  logic signed [31:0] y_q, y_d;
  logic signed [63:0] prod0_q, prod0_d, prod1_q, prod1_d;
  logic signed [31:0] a0, b0, a1, b1;
  logic sat_q, sat_d;
  logic rd_ok_q, rd_ok_d;
  logic [31:0] step_q, step_d;
  out_item_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  cell_t ram_wdata, ram_rdata;

  logic in_acc, idx_ok, emit_go, edge_left, edge_right;
  op_e op;
  logic [AW-1:0] idx_addr;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign op          = op_e'(in_data_i.operation);
  assign idx_ok      = 32'(in_data_i.cell_index) < 32'(CELLS);
  assign idx_addr    = AW'(in_data_i.cell_index);
  assign emit_go     = !out_valid_q || !out_stall_i;
  assign edge_left   = (k_q == '0);
  assign edge_right  = (k_q == KEND);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ags_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELLS)) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (k_q == KLAST) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_STEP: state_d = S_SRD;
            OP_READ: state_d = S_READ;
            default: state_d = S_EMIT;
          endcase
        end
      end
      S_READ:  state_d = S_EMIT;
      S_SRD:   state_d = S_SLAT;
      S_SLAT:  state_d = S_E1;
      S_E1:    state_d = S_E2;
      S_E2:    state_d = (edge_left || edge_right) ? S_E3 : S_U1;
      S_E3:    state_d = S_E4;
      S_E4:    state_d = edge_left ? S_SRD : S_U1;
      S_U1:    state_d = S_U2;
      S_U2: begin
        if (edge_right) begin
          state_d = S_EMIT;
        end else if (k_q == KLAST) begin
          state_d = S_E1;
        end else begin
          state_d = S_SRD;
        end
      end
      S_EMIT:  if (emit_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs of each state.
  always_comb begin
    satv_t d0, d1, q0, q1, t0, t1;
    logic clip;
    k_d         = k_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    eu_prev_d   = eu_prev_q;
    ep_prev_d   = ep_prev_q;
    eu_cur_d    = eu_cur_q;
    ep_cur_d    = ep_cur_q;
    y_d         = y_q;
    sat_d       = sat_q;
    rd_ok_d     = rd_ok_q;
    step_d      = step_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    a0 = '0;
    b0 = '0;
    a1 = '0;
    b1 = '0;
    clip = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = k_q[AW-1:0];
    ram_raddr = k_q[AW-1:0];
    ram_wdata = '0;
    d0 = dif32(cur_q.prs, prev_q.prs);
    d1 = dif32(cur_q.vel, prev_q.vel);
    q0 = mulsat(prod0_q);
    q1 = mulsat(prod1_q);
    t0 = '0;
    t1 = '0;

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        k_d    = (k_q == KLAST) ? '0 : k_q + 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          sat_d   = 1'b0;
          k_d     = '0;
          rd_ok_d = idx_ok;
          res_d   = '{velocity_out: '0, pressure_out: '0, step_count: step_q,
                      saturated: 1'b0};
          case (op)
            OP_WRITE: begin
              ram_we    = idx_ok;
              ram_waddr = idx_addr;
              ram_wdata = '{vel: in_data_i.velocity_in, prs: in_data_i.pressure_in};
              if (idx_ok) begin
                res_d.velocity_out = in_data_i.velocity_in;
                res_d.pressure_out = in_data_i.pressure_in;
              end
            end
            OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = idx_addr;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (rd_ok_q) begin
          res_d.velocity_out = ram_rdata.vel;
          res_d.pressure_out = ram_rdata.prs;
        end
      end
      S_SRD:  ram_re = 1'b1;
      S_SLAT: cur_d = ram_rdata;
      S_E1: begin
        // Boundary edges need p*inv_impedance; interior edges the scaled jumps.
        if (edge_left || edge_right) begin
          a0 = cur_q.prs;
          b0 = inv_imp;
        end else begin
          a0 = d0.val;
          b0 = inv_imp;
          a1 = d1.val;
          b1 = imp;
          clip = d0.clip || d1.clip;
        end
      end
      S_E2: begin
        if (edge_left) begin
          t0 = dif32(cur_q.vel, q0.val);
          y_d = t0.val;
          clip = q0.clip || t0.clip;
        end else if (edge_right) begin
          t0 = sat66(ext66(cur_q.vel) + ext66(q0.val));
          y_d = t0.val;
          clip = q0.clip || t0.clip;
        end else begin
          t0 = avg32(cur_q.vel, prev_q.vel, q0.val);
          t1 = avg32(cur_q.prs, prev_q.prs, q1.val);
          eu_cur_d = t0.val;
          ep_cur_d = t1.val;
          clip = q0.clip || q1.clip || t0.clip || t1.clip;
        end
      end
      S_E3: begin
        a0 = edge_left ? cfg_q[REG_LEFT_U_GAIN] : cfg_q[REG_RIGHT_U_GAIN];
        a1 = edge_left ? cfg_q[REG_LEFT_P_GAIN] : cfg_q[REG_RIGHT_P_GAIN];
        b0 = y_q;
        b1 = y_q;
      end
      S_E4: begin
        eu_cur_d = q0.val;
        ep_cur_d = q1.val;
        clip = q0.clip || q1.clip;
        if (edge_left) begin
          prev_d    = cur_q;
          eu_prev_d = q0.val;
          ep_prev_d = q1.val;
          k_d       = k_q + 1'b1;
        end
      end
      S_U1: begin
        t0 = dif32(ep_cur_q, ep_prev_q);
        t1 = dif32(eu_cur_q, eu_prev_q);
        a0 = t0.val;
        b0 = vel_gain;
        a1 = t1.val;
        b1 = prs_gain;
        clip = t0.clip || t1.clip;
      end
      S_U2: begin
        t0 = dif32(prev_q.vel, q0.val);
        t1 = dif32(prev_q.prs, q1.val);
        clip = q0.clip || q1.clip || t0.clip || t1.clip;
        ram_we    = 1'b1;
        ram_waddr = AW'(k_q - 1'b1);
        ram_wdata = '{vel: t0.val, prs: t1.val};
        prev_d    = cur_q;
        eu_prev_d = eu_cur_q;
        ep_prev_d = ep_cur_q;
        if (edge_right) begin
          // The last cell is written back; the sweep index rests at zero.
          k_d    = '0;
          step_d = step_q + 32'd1;
          res_d.step_count = step_q + 32'd1;
          res_d.saturated  = sat_q || clip;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
    if (state_q != S_IDLE) begin
      sat_d = sat_q || clip;
    end
    prod0_d = a0 * b0;
    prod1_d = a1 * b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      k_q         <= '0;
      sat_q       <= 1'b0;
      rd_ok_q     <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      sat_q       <= sat_d;
      rd_ok_q     <= rd_ok_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q    <= prev_d;
    cur_q     <= cur_d;
    eu_prev_q <= eu_prev_d;
    ep_prev_q <= ep_prev_d;
    eu_cur_q  <= eu_cur_d;
    ep_cur_q  <= ep_cur_d;
    y_q       <= y_d;
    prod0_q   <= prod0_d;
    prod1_q   <= prod1_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // The sweep counter never runs past the right boundary edge.
  `AGS_ASSERT(a_k_range, clk_i, rst_ni, k_q <= KEND)
  // The step counter only ever moves forward by one.
  `AGS_ASSERT_IMP(a_step_inc, clk_i, rst_ni, step_q != $past(step_q), step_q == $past(step_q) + 32'd1)
  // A write-back never lands on the entry being read in the same cycle.
  `AGS_ASSERT_IMP(a_ram_conflict, clk_i, rst_ni, ram_we && ram_re, ram_waddr != ram_raddr)

endmodule

`default_nettype wire
